FILE: rtl/tot_pkg.sv
// Shared types and constants for the two-opt tour improver.
// Holds field widths, request opcodes, distance term selects and the
// command/status structs that join the controller and the datapath.
package tot_pkg;

   // Field widths of the request and response channels
   localparam int CFG_W      = 7;
   localparam int OP_W       = 2;
   localparam int IDX_W      = 11;
   localparam int VAL_W      = 16;
   localparam int CITY_OUT_W = 6;
   localparam int COST_W     = 22;
   localparam int PASS_W     = 16;

   // Parameter defaults
   localparam int MAX_CITIES_DEF = 64;
   localparam int DIST_BITS_DEF  = 16;

   localparam logic [CFG_W-1:0]  CITY_COUNT_RST = 7'd64;
   localparam logic [COST_W-1:0] COST_MAX       = '1;
   localparam logic [PASS_W-1:0] PASS_MAX       = '1;

   // Request opcodes
   localparam logic [OP_W-1:0] OP_LOAD_DIST = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_TOUR = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH    = 2'd2;
   localparam logic [OP_W-1:0] OP_READ      = 2'd3;

   // Response status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Distance term selects: each edge of the tour for its cost, then the
   // edges of a 2-opt move: D0 and D1 added, D2 and D3 removed
   localparam int TERM_W = 3;
   localparam logic [TERM_W-1:0] TERM_COST = 3'd0;
   localparam logic [TERM_W-1:0] TERM_D0   = 3'd1;
   localparam logic [TERM_W-1:0] TERM_D1   = 3'd2;
   localparam logic [TERM_W-1:0] TERM_D2   = 3'd3;
   localparam logic [TERM_W-1:0] TERM_D3   = 3'd4;

   typedef struct packed {
      logic              accept;
      logic              rsp_write;
      logic              rsp_read;
      logic              rsp_search;
      logic [TERM_W-1:0] term;
      logic              rd_pa;
      logic              rd_pb;
      logic              mul;
      logic              acc_en;
      logic              k_inc;
      logic              cost_done;
      logic              pass_start;
      logic              cmp;
      logic              pass_end;
      logic              sw_ra;
      logic              sw_rb;
      logic              sw_wa;
      logic              sw_wb;
   } dp_cmd_type;

   typedef struct packed {
      logic k_last;
      logic scan_last;
      logic improved;
      logic swap_go;
      logic swap_more;
   } dp_stat_type;

endpackage

FILE: rtl/tot_dp.sv
// Datapath of the two-opt tour improver: distance and tour memories,
// index arithmetic, cost accumulator, loop counters and response registers.
// Depends on tot_pkg; driven by tot_ctrl commands.
module tot_dp #(
   parameter int MAX_CITIES = tot_pkg::MAX_CITIES_DEF,
   parameter int DIST_BITS  = tot_pkg::DIST_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [tot_pkg::CFG_W-1:0]     csr_city_count,
   input  logic [tot_pkg::OP_W-1:0]      req_op,
   input  logic [tot_pkg::IDX_W-1:0]     req_entry_index,
   input  logic [tot_pkg::VAL_W-1:0]     req_entry_value,
   input  tot_pkg::dp_cmd_type           cmd,
   output tot_pkg::dp_stat_type          stat,
   output logic                          rsp_status,
   output logic [tot_pkg::CITY_OUT_W-1:0] rsp_tour_city,
   output logic [tot_pkg::COST_W-1:0]    rsp_tour_cost,
   output logic [tot_pkg::PASS_W-1:0]    rsp_pass_count
);
   import tot_pkg::*;

   localparam int CW        = $clog2(MAX_CITIES);
   localparam int NW        = $clog2(MAX_CITIES + 1);
   localparam int TRI_DEPTH = MAX_CITIES * (MAX_CITIES - 1) / 2;
   localparam int TW        = $clog2(TRI_DEPTH);
   localparam int PW        = CW + NW + 1;
   localparam int AW_RAW    = DIST_BITS + NW + 3;
   localparam int AW        = (AW_RAW > COST_W + 2) ? AW_RAW : COST_W + 2;
   localparam logic signed [AW-1:0] COST_CAP = AW'(COST_MAX);

   // Configuration register and live city count
   logic [CFG_W-1:0] cc_ff, cc_in;
   logic [NW-1:0]    n;
   logic [2*NW-1:0]  tri_lim;

   always_comb begin
      cc_in = csr_valid ? csr_city_count : cc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff <= CITY_COUNT_RST;
      end else begin
         cc_ff <= cc_in;
      end
   end

   always_comb begin
      priority if (32'(cc_ff) < 32'd3) begin
         n = NW'(3);
      end else if (32'(cc_ff) > 32'(MAX_CITIES)) begin
         n = NW'(MAX_CITIES);
      end else begin
         n = NW'(cc_ff);
      end
      tri_lim = ((2*NW)'(n) * (2*NW)'(n - NW'(1))) >> 1;
   end

   // Request range checks
   logic dist_ok, pos_ok, city_ok;
   assign dist_ok = 32'(req_entry_index) < 32'(tri_lim);
   assign pos_ok  = 32'(req_entry_index) < 32'(n);
   assign city_ok = 32'(req_entry_value) < 32'(n);

   // Loop and move registers
   logic [CW-1:0] k_ff, i_ff, j_ff, bi_ff, bj_ff, sw_lo_ff, sw_hi_ff;
   logic [CW-1:0] city_a_ff, hi_ff;
   logic [PW-1:0] prod_ff;
   logic          zero_ff;
   logic          rd_err_ff;
   logic signed [AW-1:0] acc_ff, best_ff, before_ff;
   logic [PASS_W-1:0] passes_ff;

   function automatic logic [CW-1:0] next_pos(input logic [CW-1:0] p,
                                              input logic [NW-1:0] nn);
      logic [CW:0] q;
      q = {1'b0, p} + (CW+1)'(1);
      return (32'(q) == 32'(nn)) ? '0 : q[CW-1:0];
   endfunction

   // Tour positions of the pair selected by the current term
   logic [CW-1:0] pa, pb, i1;
   always_comb begin
      i1 = i_ff + CW'(1);
      unique case (cmd.term)
         TERM_COST: begin pa = k_ff; pb = next_pos(k_ff, n); end
         TERM_D0:   begin pa = i_ff; pb = j_ff; end
         TERM_D1:   begin pa = i1;   pb = next_pos(j_ff, n); end
         TERM_D2:   begin pa = i_ff; pb = i1; end
         TERM_D3:   begin pa = j_ff; pb = next_pos(j_ff, n); end
         default:   begin pa = k_ff; pb = k_ff; end
      endcase
   end

   // Tour memory: one write port, one registered read port
   logic [CW-1:0] tour_mem [MAX_CITIES];
   logic [CW-1:0] tour_rdata_ff, tour_raddr, tour_waddr, tour_wdata;
   logic          tour_we;

   always_comb begin
      priority if (cmd.rd_pa) begin
         tour_raddr = pa;
      end else if (cmd.rd_pb) begin
         tour_raddr = pb;
      end else if (cmd.sw_ra) begin
         tour_raddr = sw_lo_ff;
      end else if (cmd.sw_rb) begin
         tour_raddr = sw_hi_ff;
      end else begin
         tour_raddr = CW'(req_entry_index);
      end
      tour_we    = 1'b0;
      tour_waddr = CW'(req_entry_index);
      tour_wdata = CW'(req_entry_value);
      priority if (cmd.sw_wa) begin
         tour_we    = 1'b1;
         tour_waddr = sw_lo_ff;
         tour_wdata = tour_rdata_ff;
      end else if (cmd.sw_wb) begin
         tour_we    = 1'b1;
         tour_waddr = sw_hi_ff;
         tour_wdata = city_a_ff;
      end else if (cmd.accept && req_op == OP_LOAD_TOUR) begin
         tour_we    = pos_ok && city_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (tour_we) begin
         tour_mem[tour_waddr] <= tour_wdata;
      end
      tour_rdata_ff <= tour_mem[tour_raddr];
   end

   // Distance memory: upper triangle, registered read
   logic [DIST_BITS-1:0] dist_mem [TRI_DEPTH];
   logic [DIST_BITS-1:0] dist_rdata_ff;
   logic [TW-1:0]        dist_raddr;
   logic                 dist_we;

   assign dist_we    = cmd.accept && req_op == OP_LOAD_DIST && dist_ok;
   assign dist_raddr = TW'((prod_ff >> 1) + PW'(hi_ff) - PW'(1));

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[TW'(req_entry_index)] <= DIST_BITS'(req_entry_value);
      end
      dist_rdata_ff <= dist_mem[dist_raddr];
   end

   // Pair index: lo*(2n-3-lo)/2 + hi - 1
   logic [CW-1:0] ca, cb, lo_c, hi_c;
   logic [NW:0]   m_c;
   logic          zero_c;
   always_comb begin
      ca     = city_a_ff;
      cb     = tour_rdata_ff;
      lo_c   = (ca < cb) ? ca : cb;
      hi_c   = (ca < cb) ? cb : ca;
      zero_c = (ca == cb) || (32'(ca) >= 32'(n)) || (32'(cb) >= 32'(n));
      m_c    = {n, 1'b0} - (NW+1)'(3) - (NW+1)'(lo_c);
   end

   // Accumulate and compare
   logic signed [AW-1:0] term_val, cand;
   logic                 better;
   always_comb begin
      term_val = zero_ff ? '0 : signed'(AW'(dist_rdata_ff));
      cand     = before_ff + acc_ff;
      better   = cand < best_ff;
   end

   always_ff @(posedge clock) begin
      // capture first city of a pair or swap
      if (cmd.rd_pb || cmd.sw_rb) begin
         city_a_ff <= tour_rdata_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(lo_c) * PW'(m_c);
         hi_ff   <= hi_c;
         zero_ff <= zero_c;
      end
      // accumulator
      priority if (cmd.accept || cmd.pass_start || cmd.cmp) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         if (cmd.term == TERM_D2 || cmd.term == TERM_D3) begin
            acc_ff <= acc_ff - term_val;
         end else begin
            acc_ff <= acc_ff + term_val;
         end
      end
      // tour edge counter for the start cost
      if (cmd.accept) begin
         k_ff <= '0;
      end else if (cmd.k_inc) begin
         k_ff <= k_ff + CW'(1);
      end
      // best and pass baseline
      if (cmd.cost_done) begin
         best_ff <= acc_ff;
      end else if (cmd.cmp && better) begin
         best_ff <= cand;
         bi_ff   <= i_ff;
         bj_ff   <= j_ff;
      end
      if (cmd.pass_start) begin
         before_ff <= best_ff;
      end
      // pair scan counters
      if (cmd.pass_start) begin
         i_ff <= '0;
         j_ff <= CW'(1);
      end else if (cmd.cmp) begin
         if (32'(j_ff) + 32'd1 == 32'(n)) begin
            i_ff <= i1;
            j_ff <= i_ff + CW'(2);
         end else begin
            j_ff <= j_ff + CW'(1);
         end
      end
      // reversal pointers
      if (cmd.pass_end) begin
         sw_lo_ff <= bi_ff + CW'(1);
         sw_hi_ff <= bj_ff;
      end else if (cmd.sw_wb) begin
         sw_lo_ff <= sw_lo_ff + CW'(1);
         sw_hi_ff <= sw_hi_ff - CW'(1);
      end
      if (cmd.accept) begin
         rd_err_ff <= !pos_ok;
      end
   end

   // Pass counter, saturating
   always_ff @(posedge clock) begin
      if (reset) begin
         passes_ff <= '0;
      end else if (cmd.accept && req_op == OP_SEARCH) begin
         passes_ff <= '0;
      end else if (cmd.pass_end && passes_ff != PASS_MAX) begin
         passes_ff <= passes_ff + PASS_W'(1);
      end
   end

   // Response payload
   logic [COST_W-1:0] cost_clamped;
   always_comb begin
      priority if (best_ff < 0) begin
         cost_clamped = '0;
      end else if (best_ff > COST_CAP) begin
         cost_clamped = COST_MAX;
      end else begin
         cost_clamped = COST_W'(best_ff);
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.rsp_write) begin
         rsp_status     <= (req_op == OP_LOAD_DIST) ? !dist_ok : !(pos_ok && city_ok);
         rsp_tour_city  <= '0;
         rsp_tour_cost  <= '0;
         rsp_pass_count <= '0;
      end else if (cmd.rsp_read) begin
         rsp_status     <= rd_err_ff ? STATUS_ERR : STATUS_OK;
         rsp_tour_city  <= rd_err_ff ? '0 : CITY_OUT_W'(tour_rdata_ff);
         rsp_tour_cost  <= '0;
         rsp_pass_count <= '0;
      end else if (cmd.rsp_search) begin
         rsp_status     <= STATUS_OK;
         rsp_tour_city  <= '0;
         rsp_tour_cost  <= cost_clamped;
         rsp_pass_count <= passes_ff;
      end
   end

   // Status to the controller
   always_comb begin
      stat.k_last    = 32'(k_ff) + 32'd1 == 32'(n);
      stat.scan_last = (32'(j_ff) + 32'd1 == 32'(n)) && (32'(i_ff) + 32'd2 == 32'(n));
      stat.improved  = best_ff < before_ff;
      stat.swap_go   = 32'(bi_ff) + 32'd1 < 32'(bj_ff);
      stat.swap_more = 32'(sw_lo_ff) + 32'd2 < 32'(sw_hi_ff);
   end

endmodule

FILE: rtl/tot_ctrl.sv
// Controller of the two-opt tour improver: request handshake, search
// sequencer and response valid. Depends on tot_pkg; drives tot_dp.
module tot_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [tot_pkg::OP_W-1:0] req_op,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tot_pkg::dp_cmd_type      cmd,
   input  tot_pkg::dp_stat_type     stat
);
   import tot_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_PA   = 4'd2;
   localparam logic [3:0] ST_PB   = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_ADR  = 4'd5;
   localparam logic [3:0] ST_ACC  = 4'd6;
   localparam logic [3:0] ST_PASS = 4'd7;
   localparam logic [3:0] ST_CMP  = 4'd8;
   localparam logic [3:0] ST_PEND = 4'd9;
   localparam logic [3:0] ST_SRA  = 4'd10;
   localparam logic [3:0] ST_SRB  = 4'd11;
   localparam logic [3:0] ST_SWA  = 4'd12;
   localparam logic [3:0] ST_SWB  = 4'd13;
   localparam logic [3:0] ST_DONE = 4'd14;

   logic [3:0]        state_ff, state_in;
   logic [TERM_W-1:0] term_ff, term_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept, rsp_load;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_load  = cmd.rsp_write || cmd.rsp_read || cmd.rsp_search;

   // Sequence the search and issue datapath commands
   always_comb begin
      state_in = state_ff;
      term_in  = term_ff;
      cmd      = '0;
      cmd.term = term_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept) begin
               unique case (req_op)
                  OP_LOAD_DIST, OP_LOAD_TOUR: cmd.rsp_write = 1'b1;
                  OP_READ:   state_in = ST_READ;
                  OP_SEARCH: begin
                     state_in = ST_PA;
                     term_in  = TERM_COST;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            cmd.rsp_read = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_PA: begin
            cmd.rd_pa = 1'b1;
            state_in  = ST_PB;
         end
         ST_PB: begin
            cmd.rd_pb = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADR;
         end
         ST_ADR: state_in = ST_ACC;
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            priority if (term_ff == TERM_COST) begin
               if (stat.k_last) begin
                  state_in = ST_PASS;
               end else begin
                  cmd.k_inc = 1'b1;
                  state_in  = ST_PA;
               end
            end else if (term_ff == TERM_D3) begin
               state_in = ST_CMP;
            end else begin
               term_in  = term_ff + TERM_W'(1);
               state_in = ST_PA;
            end
         end
         ST_PASS: begin
            if (term_ff == TERM_COST) begin
               cmd.cost_done = 1'b1;
               term_in       = TERM_D0;
            end else begin
               cmd.pass_start = 1'b1;
               state_in       = ST_PA;
            end
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            term_in = TERM_D0;
            state_in = stat.scan_last ? ST_PEND : ST_PA;
         end
         ST_PEND: begin
            cmd.pass_end = 1'b1;
            priority if (!stat.improved) begin
               state_in = ST_DONE;
            end else if (stat.swap_go) begin
               state_in = ST_SRA;
            end else begin
               state_in = ST_PASS;
            end
         end
         ST_SRA: begin
            cmd.sw_ra = 1'b1;
            state_in  = ST_SRB;
         end
         ST_SRB: begin
            cmd.sw_rb = 1'b1;
            state_in  = ST_SWA;
         end
         ST_SWA: begin
            cmd.sw_wa = 1'b1;
            state_in  = ST_SWB;
         end
         ST_SWB: begin
            cmd.sw_wb = 1'b1;
            state_in  = stat.swap_more ? ST_SRA : ST_PASS;
         end
         ST_DONE: begin
            cmd.rsp_search = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response until taken
   always_comb begin
      priority if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_COST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Checks
   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request taken while sequencer busy");

   a_load_free_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("search finished without response");

endmodule

FILE: rtl/two_opt_tour_improver.sv
// Top level of the two-opt tour improver: controller plus datapath.
// Depends on tot_pkg, tot_ctrl and tot_dp.
//
// Usage: write csr_city_count (number of cities, clamped to 3..MAX_CITIES)
// while idle. Each request on the req_ channel gives one response on rsp_.
// Op 0 stores an upper-triangle distance, op 1 stores a tour city, op 3
// reads a tour city, op 2 runs the 2-opt search and returns cost and passes.
// Loads write the response register as they are accepted; a read first passes
// the READ state. A search sums the start cost, then runs passes that scan
// every pair, reversing the best segment after an improving pass, until a
// pass finds no gain; each distance fetch is a trip through the tour memory,
// the index multiplier and the distance memory read port.
// The response register frees the input as soon as it is taken or taken in
// the same cycle; while rsp_ready is low a finished response holds and no
// new request is accepted. Reset clears the controller and sets the city
// count to 64; memory contents are undefined until written.
module two_opt_tour_improver #(
   parameter int MAX_CITIES = tot_pkg::MAX_CITIES_DEF,
   parameter int DIST_BITS  = tot_pkg::DIST_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tot_pkg::CFG_W-1:0]      csr_city_count,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [tot_pkg::OP_W-1:0]       req_op,
   input  logic [tot_pkg::IDX_W-1:0]      req_entry_index,
   input  logic [tot_pkg::VAL_W-1:0]      req_entry_value,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_status,
   output logic [tot_pkg::CITY_OUT_W-1:0] rsp_tour_city,
   output logic [tot_pkg::COST_W-1:0]     rsp_tour_cost,
   output logic [tot_pkg::PASS_W-1:0]     rsp_pass_count
);
   import tot_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   tot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   tot_dp #(
      .MAX_CITIES (MAX_CITIES),
      .DIST_BITS  (DIST_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_city_count  (csr_city_count),
      .req_op          (req_op),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_status),
      .rsp_tour_city   (rsp_tour_city),
      .rsp_tour_cost   (rsp_tour_cost),
      .rsp_pass_count  (rsp_pass_count)
   );

endmodule

FILE: sim/two_opt_tour_improver_test.sv
// Self-checking testbench for the two-opt tour improver.
// Depends on tot_pkg and two_opt_tour_improver; predicts each response
// in the testbench and checks it field by field as it leaves the block.
module two_opt_tour_improver_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tot_pkg::*;

   localparam int TRI_MAX = MAX_CITIES_DEF * (MAX_CITIES_DEF - 1) / 2;

   typedef struct {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] val;
   } request_type;

   typedef struct {
      logic                  status;
      logic [CITY_OUT_W-1:0] city;
      logic [COST_W-1:0]     cost;
      logic [PASS_W-1:0]     passes;
   } response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic [CFG_W-1:0] csr_city_count = '0;
   logic req_valid = 1'b0;
   logic [OP_W-1:0] req_op = '0;
   logic [IDX_W-1:0] req_entry_index = '0;
   logic [VAL_W-1:0] req_entry_value = '0;
   logic rsp_ready = 1'b0;
   logic csr_ready, req_ready, rsp_valid, rsp_status;
   logic [CITY_OUT_W-1:0] rsp_tour_city;
   logic [COST_W-1:0] rsp_tour_cost;
   logic [PASS_W-1:0] rsp_pass_count;

   two_opt_tour_improver dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_city_count(csr_city_count),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_entry_index(req_entry_index), .req_entry_value(req_entry_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_tour_city(rsp_tour_city), .rsp_tour_cost(rsp_tour_cost),
      .rsp_pass_count(rsp_pass_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mirror of the block's state
   logic [VAL_W-1:0] dist_mirror [TRI_MAX];
   logic [5:0]       tour_mirror [MAX_CITIES_DEF];
   logic [CFG_W-1:0] city_count_mirror = CITY_COUNT_RST;

   // Which entries have been written, tracked as requests are queued
   bit dist_seen [TRI_MAX];
   bit pos_seen [MAX_CITIES_DEF];
   int gen_n = MAX_CITIES_DEF;

   request_type  pending_reqs [$];
   response_type expected_rsps [$];
   int sent_cnt = 0, done_cnt = 0, mismatches = 0, searches = 0, cfg_writes = 0;
   bit steady = 1'b0;

   function automatic int clamp_n(logic [CFG_W-1:0] v);
      if (v < 3) return 3;
      if (v > MAX_CITIES_DEF) return MAX_CITIES_DEF;
      return v;
   endfunction

   function automatic longint edge_len(int a, int b, int n);
      int lo, hi;
      if (a == b || a >= n || b >= n) return 0;
      lo = a < b ? a : b;
      hi = a < b ? b : a;
      return dist_mirror[lo * (n - 1) + hi - 1 - lo * (lo + 1) / 2];
   endfunction

   // Best-improvement 2-opt on the mirrored tour; returns final cost and passes
   function automatic response_type search_tour(int n);
      response_type r;
      longint best, start, delta;
      int passes, bi, bj, lo, hi;
      logic [5:0] t;
      best = 0;
      passes = 0;
      bi = 0;
      bj = 0;
      for (int k = 0; k < n; k++)
         best += edge_len(tour_mirror[k], tour_mirror[(k + 1) % n], n);
      do begin
         start = best;
         for (int i = 0; i + 1 < n; i++)
            for (int j = i + 1; j < n; j++) begin
               delta = edge_len(tour_mirror[i], tour_mirror[j], n)
                     + edge_len(tour_mirror[i+1], tour_mirror[(j+1) % n], n)
                     - edge_len(tour_mirror[i], tour_mirror[i+1], n)
                     - edge_len(tour_mirror[j], tour_mirror[(j+1) % n], n);
               if (start + delta < best) begin
                  best = start + delta;
                  bi = i;
                  bj = j;
               end
            end
         if (best < start) begin
            lo = bi + 1;
            hi = bj;
            while (lo < hi) begin
               t = tour_mirror[lo];
               tour_mirror[lo] = tour_mirror[hi];
               tour_mirror[hi] = t;
               lo++;
               hi--;
            end
         end
         if (passes < 65535) passes++;
      end while (best < start);
      if (best < 0) best = 0;
      r.status = STATUS_OK;
      r.city = '0;
      r.cost = best > 4194303 ? COST_MAX : best[COST_W-1:0];
      r.passes = passes[PASS_W-1:0];
      return r;
   endfunction

   function automatic response_type predict_response(request_type q);
      response_type r;
      int n;
      n = clamp_n(city_count_mirror);
      r = '{STATUS_OK, '0, '0, '0};
      case (q.op)
         OP_LOAD_DIST: begin
            if (q.idx < n * (n - 1) / 2) dist_mirror[q.idx] = q.val;
            else r.status = STATUS_ERR;
         end
         OP_LOAD_TOUR: begin
            if (q.idx < n && q.val < n) tour_mirror[q.idx] = q.val[5:0];
            else r.status = STATUS_ERR;
         end
         OP_SEARCH: r = search_tour(n);
         default: begin
            if (q.idx < n) r.city = tour_mirror[q.idx];
            else r.status = STATUS_ERR;
         end
      endcase
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none in steady stretches
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: advance to the next queued request once the current one is taken
   int send_gap = 0;
   always @(posedge clock) begin
      request_type q;
      logic nv;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            q = '{req_op, req_entry_index, req_entry_value};
            expected_rsps.push_back(predict_response(q));
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               q = pending_reqs.pop_front();
               req_op <= q.op;
               req_entry_index <= q.idx;
               req_entry_value <= q.val;
               nv = 1'b1;
               send_gap = pick_gap();
            end
         end
         req_valid <= nv;
      end
   end

   // Monitor: check each response against the oldest prediction
   int hold = 0;
   always @(posedge clock) begin
      response_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            done_cnt++;
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response, nothing pending");
            end else begin
               e = expected_rsps.pop_front();
               if (e.status !== rsp_status || e.city !== rsp_tour_city ||
                   e.cost !== rsp_tour_cost || e.passes !== rsp_pass_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp st=%0d city=%0d cost=%0d pass=%0d, got %0d %0d %0d %0d",
                              e.status, e.city, e.cost, e.passes, rsp_status,
                              rsp_tour_city, rsp_tour_cost, rsp_pass_count);
               end
            end
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold = pick_gap();
         end
      end
   end

   task automatic push_req(logic [OP_W-1:0] op, int idx, int val);
      request_type q;
      q = '{op, idx[IDX_W-1:0], val[VAL_W-1:0]};
      if (op == OP_LOAD_DIST && q.idx < gen_n * (gen_n - 1) / 2) dist_seen[q.idx] = 1'b1;
      if (op == OP_LOAD_TOUR && q.idx < gen_n && q.val < gen_n) pos_seen[q.idx] = 1'b1;
      if (op == OP_SEARCH) searches++;
      pending_reqs.push_back(q);
      sent_cnt++;
   endtask

   task automatic wait_idle();
      while (done_cnt != sent_cnt) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_city_count(int v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_city_count <= v[CFG_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      city_count_mirror = v[CFG_W-1:0];
      gen_n = clamp_n(v[CFG_W-1:0]);
      cfg_writes++;
   endtask

   function automatic bit search_safe();
      for (int k = 0; k < gen_n; k++) if (!pos_seen[k]) return 1'b0;
      for (int k = 0; k < gen_n * (gen_n - 1) / 2; k++) if (!dist_seen[k]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic int rand_dist();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 999) : $urandom_range(0, 65535);
   endfunction

   // Fill the whole triangle and a shuffled tour for the current city count
   task automatic load_all();
      int perm [MAX_CITIES_DEF];
      int j, t;
      for (int k = 0; k < gen_n * (gen_n - 1) / 2; k++) push_req(OP_LOAD_DIST, k, rand_dist());
      for (int k = 0; k < gen_n; k++) perm[k] = k;
      for (int k = gen_n - 1; k > 0; k--) begin
         j = $urandom_range(0, k);
         t = perm[k];
         perm[k] = perm[j];
         perm[j] = t;
      end
      for (int k = 0; k < gen_n; k++) push_req(OP_LOAD_TOUR, k, perm[k]);
   endtask

   // Random mix of loads, reads and searches that never touches unwritten entries
   task automatic random_mix(int count, bit allow_search);
      int tri_n, r, idx;
      tri_n = gen_n * (gen_n - 1) / 2;
      for (int c = 0; c < count; c++) begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            idx = ($urandom_range(0, 99) < 85) ? $urandom_range(0, tri_n - 1)
                                               : $urandom_range(tri_n, 2047);
            push_req(OP_LOAD_DIST, idx, rand_dist());
         end else if (r < 55) begin
            if ($urandom_range(0, 99) < 80)
               push_req(OP_LOAD_TOUR, $urandom_range(0, gen_n - 1), $urandom_range(0, gen_n - 1));
            else
               push_req(OP_LOAD_TOUR, $urandom_range(0, 2047), $urandom_range(0, 65535));
         end else if (r < 85 || !allow_search || !search_safe()) begin
            if ($urandom_range(0, 99) < 85) begin
               do idx = $urandom_range(0, gen_n - 1); while (!pos_seen[idx]);
            end else begin
               idx = $urandom_range(gen_n, 2047);
            end
            push_req(OP_READ, idx, $urandom_range(0, 65535));
         end else begin
            push_req(OP_SEARCH, $urandom_range(0, 2047), $urandom_range(0, 65535));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Three cities: field extremes, every error, duplicate city
      write_city_count(3);
      push_req(OP_LOAD_DIST, 0, 0);
      push_req(OP_LOAD_DIST, 1, 65535);
      push_req(OP_LOAD_DIST, 2, 1);
      push_req(OP_LOAD_DIST, 3, 7);
      push_req(OP_LOAD_DIST, 2047, 65535);
      push_req(OP_LOAD_TOUR, 0, 1);
      push_req(OP_LOAD_TOUR, 1, 1);
      push_req(OP_LOAD_TOUR, 2, 2);
      push_req(OP_LOAD_TOUR, 3, 0);
      push_req(OP_LOAD_TOUR, 0, 3);
      push_req(OP_LOAD_TOUR, 2047, 65535);
      push_req(OP_READ, 0, 0);
      push_req(OP_READ, 2047, 65535);
      push_req(OP_SEARCH, 0, 0);
      push_req(OP_LOAD_TOUR, 1, 0);
      push_req(OP_SEARCH, 2047, 65535);
      push_req(OP_READ, 1, 0);
      push_req(OP_READ, 2, 0);
      wait_idle();

      // Zero acts as three cities
      write_city_count(0);
      load_all();
      random_mix(5, 1'b1);
      wait_idle();

      steady = 1'b1;
      write_city_count(6);
      load_all();
      random_mix(10, 1'b1);
      wait_idle();
      steady = 1'b0;

      // Above the maximum acts as the maximum; no search here
      write_city_count(127);
      random_mix(6, 1'b0);
      wait_idle();

      // Shrink to five: cities left over from the larger tours are stale
      write_city_count(5);
      random_mix(4, 1'b1);
      push_req(OP_SEARCH, 0, 0);
      load_all();
      random_mix(10, 1'b1);
      wait_idle();

      repeat (20) @(posedge clock);
      $display("covered %0d requests, %0d searches, %0d city count writes from 0 to 127",
               sent_cnt, searches, cfg_writes);
      $display("%0d responses checked, %0d mismatches", done_cnt, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog
   initial begin
      #100ms;
      $display("tb: failure");
      $finish;
   end

endmodule
